/* hw/rtl/etm_pkg.sv */
// engine torque map package: constants, codes, divider handshake types
// and the point-count helper; no dependencies
package etm_pkg;

   localparam int MAX_SPEED_ROWS_DEF    = 32;
   localparam int MAX_PEDAL_COLUMNS_DEF = 32;

   localparam int PT_W  = 9;
   localparam int RPM_W = 39;
   localparam logic [22:0] RPM_SCALE = 23'd5006582;

   localparam int DIV_W     = 58;
   localparam int DIV_Q     = 17;
   localparam int DIV_CNT_W = 5;

   localparam logic [15:0] TORQUE_LIMITED = 16'hF9C0;
   localparam logic [15:0] PEDAL_FULL     = 16'h8000;

   localparam logic [1:0] MODE_WRITE    = 2'd0;
   localparam logic [1:0] MODE_TORQUE   = 2'd1;
   localparam logic [1:0] MODE_THROTTLE = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ABOVE = 2'd1;
   localparam logic [1:0] ST_BELOW = 2'd2;

   localparam logic KIND_TORQUE = 1'b0;
   localparam logic KIND_PEDAL  = 1'b1;

   localparam logic [2:0] REG_SPEED_LOW  = 3'd0;
   localparam logic [2:0] REG_SPEED_HIGH = 3'd1;
   localparam logic [2:0] REG_SPEED_PTS  = 3'd2;
   localparam logic [2:0] REG_PEDAL_LOW  = 3'd3;
   localparam logic [2:0] REG_PEDAL_HIGH = 3'd4;
   localparam logic [2:0] REG_PEDAL_PTS  = 3'd5;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_Q-1:0] quot;
   } div_rsp_type;

   function automatic logic [PT_W-1:0] used_points(input logic [5:0] pts,
                                                   input logic [PT_W-1:0] limit);
      logic [PT_W-1:0] ext;
      ext = PT_W'(pts);
      if (pts == 6'd0) return PT_W'(1);
      if (ext > limit) return limit;
      return ext;
   endfunction

endpackage

/* hw/rtl/etm_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on etm_pkg
module etm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  etm_pkg::div_req_type req,
   output etm_pkg::div_rsp_type rsp
);

   logic [etm_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [etm_pkg::DIV_W-1:0]     dsh_ff, dsh_in;
   logic [etm_pkg::DIV_Q-1:0]     quot_ff, quot_in;
   logic [etm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = req.den << (etm_pkg::DIV_Q - 1);
         quot_in = '0;
         cnt_in  = etm_pkg::DIV_CNT_W'(etm_pkg::DIV_Q - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[etm_pkg::DIV_Q-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[etm_pkg::DIV_Q-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

/* hw/rtl/etm_table.sv */
// torque table memory, one write and one registered read port
// no dependencies
module etm_table #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [15:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [15:0]              rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/engine_torque_map_lookup.sv */
// engine torque map top: register port, sequencer, table and shared divider
// depends on etm_pkg, etm_div, etm_table
// torque lookup: out of speed range the divisions and table read are skipped; a write keeps the block idle
// throttle lookup: the scan runs up to the first entry above target; at full it is skipped
// each division holds the sequencer until the divider is done; next word taken the cycle after the result is
// registered, a stalled result holds the block; sync reset clears control, not the table
module engine_torque_map_lookup #(
   parameter int MAX_SPEED_ROWS    = etm_pkg::MAX_SPEED_ROWS_DEF,
   parameter int MAX_PEDAL_COLUMNS = etm_pkg::MAX_PEDAL_COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // speed_rad, pedal_in, target_torque, entry_row, entry_column, entry_torque
   input  logic [79:0] req_tdata,
   // mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // torque_out, pedal_out, speed_status
   output logic [39:0] rsp_tdata,
   // result_kind
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH = MAX_SPEED_ROWS * MAX_PEDAL_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_SPEED_ROWS);
   localparam int CW    = $clog2(MAX_PEDAL_COLUMNS);
   localparam int MAG_W = CW + 16;
   localparam int PW    = etm_pkg::PT_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MUL      = 4'd1;
   localparam logic [3:0] S_CMP      = 4'd2;
   localparam logic [3:0] S_ROW_PREP = 4'd3;
   localparam logic [3:0] S_ROW_DIV  = 4'd4;
   localparam logic [3:0] S_COL_PREP = 4'd5;
   localparam logic [3:0] S_COL_DIV  = 4'd6;
   localparam logic [3:0] S_RD       = 4'd7;
   localparam logic [3:0] S_RD_WAIT  = 4'd8;
   localparam logic [3:0] S_LAST_RD  = 4'd9;
   localparam logic [3:0] S_LAST_CHK = 4'd10;
   localparam logic [3:0] S_SCAN     = 4'd11;
   localparam logic [3:0] S_PED_PREP = 4'd12;
   localparam logic [3:0] S_PED_DIV  = 4'd13;
   localparam logic [3:0] S_PED_FIN  = 4'd14;
   localparam logic [3:0] S_OUT      = 4'd15;

   // configuration registers
   logic [14:0] spd_low_ff, spd_high_ff;
   logic [5:0]  spd_pts_ff, ped_pts_ff;
   logic [15:0] ped_low_ff, ped_high_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_low_ff  <= '0;
         spd_high_ff <= '0;
         spd_pts_ff  <= '0;
         ped_low_ff  <= '0;
         ped_high_ff <= '0;
         ped_pts_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            etm_pkg::REG_SPEED_LOW:  spd_low_ff  <= csr_pwdata[14:0];
            etm_pkg::REG_SPEED_HIGH: spd_high_ff <= csr_pwdata[14:0];
            etm_pkg::REG_SPEED_PTS:  spd_pts_ff  <= csr_pwdata[5:0];
            etm_pkg::REG_PEDAL_LOW:  ped_low_ff  <= csr_pwdata[15:0];
            etm_pkg::REG_PEDAL_HIGH: ped_high_ff <= csr_pwdata[15:0];
            etm_pkg::REG_PEDAL_PTS:  ped_pts_ff  <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         etm_pkg::REG_SPEED_LOW:  csr_prdata = 32'(spd_low_ff);
         etm_pkg::REG_SPEED_HIGH: csr_prdata = 32'(spd_high_ff);
         etm_pkg::REG_SPEED_PTS:  csr_prdata = 32'(spd_pts_ff);
         etm_pkg::REG_PEDAL_LOW:  csr_prdata = 32'(ped_low_ff);
         etm_pkg::REG_PEDAL_HIGH: csr_prdata = 32'(ped_high_ff);
         etm_pkg::REG_PEDAL_PTS:  csr_prdata = 32'(ped_pts_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // derived map geometry
   logic [PW-1:0]                rows_w, cols_w, rows_m1, cols_m1;
   logic [etm_pkg::RPM_W-1:0]    lo_rpm, hi_rpm;

   assign rows_w  = etm_pkg::used_points(spd_pts_ff, PW'(MAX_SPEED_ROWS));
   assign cols_w  = etm_pkg::used_points(ped_pts_ff, PW'(MAX_PEDAL_COLUMNS));
   assign rows_m1 = rows_w - 1'b1;
   assign cols_m1 = cols_w - 1'b1;
   assign lo_rpm  = {spd_low_ff, 24'd0};
   assign hi_rpm  = {spd_high_ff, 24'd0};

   // sequencer state
   logic [3:0]                state_ff, state_in;
   logic [1:0]                mode_ff;
   logic [15:0]               speed_ff, pedal_ff;
   logic signed [15:0]        target_ff;
   logic [etm_pkg::RPM_W-1:0] rpm_ff;
   logic [47:0]               prod_ff;
   logic [1:0]                status_ff;
   logic [RW-1:0]             row_ff;
   logic [CW-1:0]             col_ff;
   logic [PW-1:0]             cnt_ff;
   logic                      chk_ff;
   logic [PW-1:0]             chk_idx_ff;
   logic [etm_pkg::DIV_Q-1:0] term_ff;
   logic [15:0]               res_torque_ff, res_pedal_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic [15:0]               rsp_torque_ff, rsp_pedal_ff;
   logic [1:0]                rsp_status_ff;

   logic                      accept, tbl_wr, out_free;
   logic [4:0]                e_row, e_col;
   logic [AW-1:0]             wr_addr, rd_addr, row_base;
   logic signed [15:0]        rd_data;
   logic [15:0]               p_clamp;
   logic [24:0]               col_prod;
   logic [16:0]               span;
   logic [15:0]               span_mag;
   logic [MAG_W-1:0]          ped_mag;
   logic signed [18:0]        ped_val;
   etm_pkg::div_req_type      div_req;
   etm_pkg::div_rsp_type      div_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign e_row      = req_tdata[52:48];
   assign e_col      = req_tdata[57:53];
   assign tbl_wr     = accept && (req_tuser == etm_pkg::MODE_WRITE)
                       && (32'(e_row) < MAX_SPEED_ROWS) && (32'(e_col) < MAX_PEDAL_COLUMNS);
   assign wr_addr    = AW'(e_row) * AW'(MAX_PEDAL_COLUMNS) + AW'(e_col);
   assign row_base   = AW'(row_ff) * AW'(MAX_PEDAL_COLUMNS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (state_ff)
         S_LAST_RD: rd_addr = row_base + AW'(cols_m1[CW-1:0]);
         S_SCAN:    rd_addr = row_base + AW'((cnt_ff < cols_w) ? cnt_ff[CW-1:0]
                                                                 : cols_m1[CW-1:0]);
         default:   rd_addr = row_base + AW'(col_ff);
      endcase
   end

   etm_table #(.DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[73:58]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // datapath helpers
   always_comb begin
      p_clamp = pedal_ff;
      if (p_clamp < ped_low_ff) p_clamp = ped_low_ff;
      if (p_clamp > ped_high_ff) p_clamp = ped_high_ff;
   end

   assign col_prod = (p_clamp - ped_low_ff) * cols_m1;
   assign span     = {1'b0, ped_high_ff} - {1'b0, ped_low_ff};
   assign span_mag = span[16] ? 16'(-span) : span[15:0];
   assign ped_mag  = col_ff * span_mag;
   assign ped_val  = span[16] ? (19'sd0 + $signed({3'b0, ped_low_ff}) - $signed({2'b0, term_ff}))
                              : (19'sd0 + $signed({3'b0, ped_low_ff}) + $signed({2'b0, term_ff}));

   always_comb begin
      div_req = '0;
      unique case (state_ff)
         S_ROW_PREP: begin
            div_req.start = (status_ff == etm_pkg::ST_OK) && (hi_rpm > lo_rpm);
            div_req.num   = etm_pkg::DIV_W'({prod_ff, 1'b0})
                            + etm_pkg::DIV_W'(hi_rpm - lo_rpm);
            div_req.den   = etm_pkg::DIV_W'({hi_rpm - lo_rpm, 1'b0});
         end
         S_COL_PREP: begin
            div_req.start = (ped_high_ff > ped_low_ff);
            div_req.num   = etm_pkg::DIV_W'({col_prod, 1'b0})
                            + etm_pkg::DIV_W'(ped_high_ff - ped_low_ff);
            div_req.den   = etm_pkg::DIV_W'({ped_high_ff - ped_low_ff, 1'b0});
         end
         S_PED_PREP: begin
            div_req.start = (cols_w > PW'(1));
            div_req.num   = etm_pkg::DIV_W'({ped_mag, 1'b0}) + etm_pkg::DIV_W'(cols_m1);
            div_req.den   = etm_pkg::DIV_W'({cols_m1, 1'b0});
         end
         default: ;
      endcase
   end

   etm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == etm_pkg::MODE_TORQUE
                           || req_tuser == etm_pkg::MODE_THROTTLE)) begin
               state_in = S_MUL;
            end
         end
         S_MUL:      state_in = S_CMP;
         S_CMP:      state_in = S_ROW_PREP;
         S_ROW_PREP: begin
            if (status_ff != etm_pkg::ST_OK) state_in = S_OUT;
            else if (div_req.start) state_in = S_ROW_DIV;
            else if (mode_ff == etm_pkg::MODE_TORQUE) state_in = S_COL_PREP;
            else state_in = S_LAST_RD;
         end
         S_ROW_DIV: begin
            if (div_rsp.done) begin
               state_in = (mode_ff == etm_pkg::MODE_TORQUE) ? S_COL_PREP : S_LAST_RD;
            end
         end
         S_COL_PREP: state_in = div_req.start ? S_COL_DIV : S_RD;
         S_COL_DIV:  if (div_rsp.done) state_in = S_RD;
         S_RD:       state_in = S_RD_WAIT;
         S_RD_WAIT:  state_in = S_OUT;
         S_LAST_RD:  state_in = S_LAST_CHK;
         S_LAST_CHK: state_in = (rd_data < target_ff) ? S_OUT : S_SCAN;
         S_SCAN: begin
            if (chk_ff && (rd_data > target_ff || chk_idx_ff == cols_m1)) begin
               state_in = S_PED_PREP;
            end
         end
         S_PED_PREP: state_in = div_req.start ? S_PED_DIV : S_PED_FIN;
         S_PED_DIV:  if (div_rsp.done) state_in = S_PED_FIN;
         S_PED_FIN:  state_in = S_OUT;
         S_OUT:      if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_LAST_CHK) begin
            cnt_ff <= '0;
            chk_ff <= 1'b0;
         end else if (state_ff == S_SCAN) begin
            if (cnt_ff < cols_w) cnt_ff <= cnt_ff + 1'b1;
            chk_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            mode_ff       <= req_tuser;
            speed_ff      <= req_tdata[15:0];
            pedal_ff      <= req_tdata[31:16];
            target_ff     <= req_tdata[47:32];
            res_torque_ff <= '0;
            res_pedal_ff  <= '0;
            row_ff        <= '0;
            col_ff        <= '0;
         end
         S_MUL: rpm_ff <= speed_ff * etm_pkg::RPM_SCALE;
         S_CMP: begin
            prod_ff <= (rpm_ff - lo_rpm) * rows_m1;
            if (rpm_ff > hi_rpm) status_ff <= etm_pkg::ST_ABOVE;
            else if (rpm_ff < lo_rpm) status_ff <= etm_pkg::ST_BELOW;
            else status_ff <= etm_pkg::ST_OK;
         end
         S_ROW_PREP: begin
            if (status_ff == etm_pkg::ST_ABOVE && mode_ff == etm_pkg::MODE_TORQUE) begin
               res_torque_ff <= etm_pkg::TORQUE_LIMITED;
            end
         end
         S_ROW_DIV: if (div_rsp.done) row_ff <= div_rsp.quot[RW-1:0];
         S_COL_DIV: if (div_rsp.done) col_ff <= div_rsp.quot[CW-1:0];
         S_RD_WAIT: res_torque_ff <= rd_data;
         S_LAST_CHK: if (rd_data < target_ff) res_pedal_ff <= etm_pkg::PEDAL_FULL;
         S_SCAN: begin
            chk_idx_ff <= cnt_ff;
            if (chk_ff && rd_data > target_ff) col_ff <= chk_idx_ff[CW-1:0];
         end
         S_PED_PREP: term_ff <= '0;
         S_PED_DIV: if (div_rsp.done) term_ff <= div_rsp.quot;
         S_PED_FIN: begin
            if (ped_val < 19'sd0) res_pedal_ff <= '0;
            else if (ped_val > 19'sd32768) res_pedal_ff <= etm_pkg::PEDAL_FULL;
            else res_pedal_ff <= ped_val[15:0];
         end
         S_OUT: begin
            if (out_free) begin
               rsp_kind_ff   <= (mode_ff == etm_pkg::MODE_THROTTLE) ? etm_pkg::KIND_PEDAL
                                                                    : etm_pkg::KIND_TORQUE;
               rsp_torque_ff <= res_torque_ff;
               rsp_pedal_ff  <= res_pedal_ff;
               rsp_status_ff <= status_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_pedal_ff, rsp_torque_ff};

endmodule

/* hw/rtl/etm_checker.sv */
// port-level checks for the engine torque map block, bound to the top level
// depends on etm_pkg and engine_torque_map_lookup
module etm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled word stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped under stall");

   a_torque_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == etm_pkg::KIND_TORQUE |-> rsp_tdata[31:16] == 16'd0)
      else $error("torque word carries a throttle");

   a_pedal_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == etm_pkg::KIND_PEDAL
      |-> rsp_tdata[15:0] == 16'd0 && rsp_tdata[31:16] <= etm_pkg::PEDAL_FULL)
      else $error("throttle word malformed");

   a_limited: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == etm_pkg::KIND_TORQUE && rsp_tdata[33:32] == etm_pkg::ST_ABOVE
      |-> rsp_tdata[15:0] == etm_pkg::TORQUE_LIMITED)
      else $error("over-speed torque not limited");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != etm_pkg::ST_OK
      |-> rsp_tdata[31:16] == 16'd0)
      else $error("throttle given out of speed range");

endmodule

bind engine_torque_map_lookup etm_checker u_etm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* dv/engine_torque_map_lookup_tb.sv */
// testbench for engine_torque_map_lookup: random and directed table writes, torque and
// throttle lookups over several map settings, checked against an in-bench model of the map
// depends on etm_pkg and the engine_torque_map_lookup rtl
`timescale 1ns / 1ps

module engine_torque_map_lookup_tb;

   localparam int unsigned ROWS = 32;
   localparam int unsigned COLS = 32;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE = 120;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        speed;
      logic [15:0]        pedal;
      logic signed [15:0] target;
      logic [4:0]         row;
      logic [4:0]         col;
      logic signed [15:0] torque;
   } map_req_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] torque;
      logic [15:0]        pedal;
      logic [1:0]         status;
   } map_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   engine_torque_map_lookup dut (.*);

   always #2 clock = ~clock;

   // map settings as seen by the predictor
   int unsigned cfg_speed_lo, cfg_speed_hi, cfg_speed_pts;
   int unsigned cfg_pedal_lo, cfg_pedal_hi, cfg_pedal_pts;

   logic signed [15:0] torque_map [ROWS*COLS];
   bit                 entry_loaded [ROWS*COLS];

   map_req_type pending_words[$];
   map_rsp_type expected_answers[$];
   map_req_type cur_word;

   bit          failed = 1'b0;
   bit          calm = 1'b0;
   bit          word_taken = 1'b0;
   int unsigned req_gap = 0, rsp_gap = 0, cycles = 0;

   function automatic int unsigned used_count(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // speed status, nearest row and (torque lookup) nearest column
   function automatic void locate(input map_req_type w, output logic [1:0] st,
                                  output int unsigned row, output int unsigned col);
      longint unsigned rpm, lo, hi;
      int unsigned     rows, cols, p;
      rows = used_count(cfg_speed_pts, ROWS);
      cols = used_count(cfg_pedal_pts, COLS);
      rpm = longint'(w.speed) * 64'd5006582;
      lo = longint'(cfg_speed_lo) << 24;
      hi = longint'(cfg_speed_hi) << 24;
      st = etm_pkg::ST_OK;
      if (rpm > hi) st = etm_pkg::ST_ABOVE;
      else if (rpm < lo) st = etm_pkg::ST_BELOW;
      row = 0;
      col = 0;
      if (st == etm_pkg::ST_OK && hi > lo) row = round_div((rpm - lo) * (rows - 1), hi - lo);
      if (cfg_pedal_hi > cfg_pedal_lo) begin
         p = w.pedal;
         if (p < cfg_pedal_lo) p = cfg_pedal_lo;
         if (p > cfg_pedal_hi) p = cfg_pedal_hi;
         col = round_div(longint'(p - cfg_pedal_lo) * (cols - 1), cfg_pedal_hi - cfg_pedal_lo);
      end
   endfunction

   function automatic map_rsp_type predict_answer(map_req_type w);
      map_rsp_type r;
      logic [1:0]  st;
      int unsigned row, col, cols, hit;
      longint      num, q, val;
      locate(w, st, row, col);
      cols = used_count(cfg_pedal_pts, COLS);
      r.kind = (w.mode == etm_pkg::MODE_THROTTLE) ? etm_pkg::KIND_PEDAL : etm_pkg::KIND_TORQUE;
      r.torque = '0;
      r.pedal = '0;
      r.status = st;
      if (w.mode == etm_pkg::MODE_TORQUE) begin
         if (st == etm_pkg::ST_ABOVE) r.torque = etm_pkg::TORQUE_LIMITED;
         else if (st == etm_pkg::ST_OK) r.torque = torque_map[row*COLS + col];
      end else if (st == etm_pkg::ST_OK) begin
         if (torque_map[row*COLS + cols - 1] < w.target) begin
            r.pedal = etm_pkg::PEDAL_FULL;
         end else begin
            hit = 0;
            for (int unsigned i = 0; i < cols; i++)
               if (torque_map[row*COLS + i] > w.target) begin
                  hit = i;
                  break;
               end
            q = 0;
            if (cols > 1) begin
               num = longint'(hit) * (longint'(cfg_pedal_hi) - longint'(cfg_pedal_lo));
               q = round_div((num < 0) ? -num : num, cols - 1);
               if (num < 0) q = -q;
            end
            val = longint'(cfg_pedal_lo) + q;
            if (val < 0) val = 0;
            if (val > 32768) val = 32768;
            r.pedal = val[15:0];
         end
      end
      return r;
   endfunction

   // first table entry a lookup would read before it was loaded
   function automatic bit missing_entry(map_req_type w, output int unsigned idx);
      logic [1:0]  st;
      int unsigned row, col;
      locate(w, st, row, col);
      idx = 0;
      if (st != etm_pkg::ST_OK) return 1'b0;
      if (w.mode == etm_pkg::MODE_TORQUE) begin
         idx = row*COLS + col;
         return !entry_loaded[idx];
      end
      if (w.mode == etm_pkg::MODE_THROTTLE)
         for (int unsigned i = 0; i < used_count(cfg_pedal_pts, COLS); i++)
            if (!entry_loaded[row*COLS + i]) begin
               idx = row*COLS + i;
               return 1'b1;
            end
      return 1'b0;
   endfunction

   function automatic map_req_type random_word(logic [1:0] mode);
      map_req_type w;
      w.mode = mode;
      w.speed = $urandom;
      w.pedal = $urandom;
      w.target = $urandom;
      w.row = $urandom;
      w.col = $urandom;
      w.torque = $urandom;
      return w;
   endfunction

   int unsigned queued = 0;

   task automatic queue_word(map_req_type w);
      map_req_type fill;
      int unsigned idx;
      while (missing_entry(w, idx)) begin
         fill = random_word(etm_pkg::MODE_WRITE);
         fill.row = idx / COLS;
         fill.col = idx % COLS;
         entry_loaded[idx] = 1'b1;
         pending_words.push_back(fill);
         queued++;
      end
      if (w.mode == etm_pkg::MODE_WRITE) entry_loaded[w.row*COLS + w.col] = 1'b1;
      pending_words.push_back(w);
      queued++;
   endtask

   task automatic csr_write(logic [2:0] idx, int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         etm_pkg::REG_SPEED_LOW:  cfg_speed_lo = value & 16'h7FFF;
         etm_pkg::REG_SPEED_HIGH: cfg_speed_hi = value & 16'h7FFF;
         etm_pkg::REG_SPEED_PTS:  cfg_speed_pts = value & 6'h3F;
         etm_pkg::REG_PEDAL_LOW:  cfg_pedal_lo = value & 16'hFFFF;
         etm_pkg::REG_PEDAL_HIGH: cfg_pedal_hi = value & 16'hFFFF;
         default:                 cfg_pedal_pts = value & 6'h3F;
      endcase
   endtask

   task automatic set_map(int unsigned slo, int unsigned shi, int unsigned spts,
                          int unsigned plo, int unsigned phi, int unsigned ppts);
      csr_write(etm_pkg::REG_SPEED_LOW, slo);
      csr_write(etm_pkg::REG_SPEED_HIGH, shi);
      csr_write(etm_pkg::REG_SPEED_PTS, spts);
      csr_write(etm_pkg::REG_PEDAL_LOW, plo);
      csr_write(etm_pkg::REG_PEDAL_HIGH, phi);
      csr_write(etm_pkg::REG_PEDAL_PTS, ppts);
   endtask

   task automatic drain;
      do begin
         @(negedge clock);
         #1;
      end while (pending_words.size() != 0 || req_tvalid || expected_answers.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned stop_at, pick;
      stop_at = queued + count;
      while (queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) queue_word(random_word(etm_pkg::MODE_WRITE));
         else if (pick < 60) queue_word(random_word(etm_pkg::MODE_TORQUE));
         else if (pick < 95) queue_word(random_word(etm_pkg::MODE_THROTTLE));
         else queue_word(random_word(etm_pkg::MODE_NONE));
      end
   endtask

   map_req_type w;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: boundaries of speed, throttle, torque and target
      set_map(1000, 8000, 32, 0, 32768, 32);
      w = random_word(etm_pkg::MODE_WRITE); w.row = 0; w.col = 0; w.torque = -16'sd32768;
      queue_word(w);
      w = random_word(etm_pkg::MODE_WRITE); w.row = 31; w.col = 31; w.torque = 16'sd32767;
      queue_word(w);
      w = random_word(etm_pkg::MODE_TORQUE); w.speed = 0; queue_word(w);
      w = random_word(etm_pkg::MODE_TORQUE); w.speed = 16'hFFFF; queue_word(w);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 0; queue_word(w);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 16'hFFFF; queue_word(w);
      w = random_word(etm_pkg::MODE_NONE); queue_word(w);
      w = random_word(etm_pkg::MODE_TORQUE); w.speed = 3352; w.pedal = 0; queue_word(w);
      w = random_word(etm_pkg::MODE_TORQUE); w.speed = 26800; w.pedal = 16'hFFFF;
      queue_word(w);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 3352; w.target = -16'sd32768;
      queue_word(w);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 26800; w.target = 16'sd32767;
      queue_word(w);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 26800; w.target = 16'sd32766;
      queue_word(w);
      drain();

      // degenerate and saturating settings
      set_map(0, 20000, 0, 65535, 0, 0);
      random_phase(120);
      drain();
      set_map(3000, 3000, 1, 100, 200, 1);
      w = random_word(etm_pkg::MODE_TORQUE); w.speed = 10054; queue_word(w);
      random_phase(100);
      drain();
      set_map(0, 0, 63, 0, 65535, 63);
      w = random_word(etm_pkg::MODE_THROTTLE); w.speed = 0; queue_word(w);
      random_phase(100);
      drain();
      set_map(0, 20000, 32, 0, 32768, 32);
      random_phase(200);
      drain();

      for (int p = 0; p < 7; p++) begin
         int unsigned slo;
         slo = $urandom_range(0, 15000);
         set_map(slo, $urandom_range(0, 9) == 0 ? $urandom_range(0, 20000)
                                                 : $urandom_range(slo, 20000),
                 $urandom_range(0, 40), $urandom_range(0, 40000), $urandom_range(0, 65535),
                 $urandom_range(0, 40));
         if (p == 6) calm = 1'b1;
         random_phase(130);
         drain();
      end

      if (!failed) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // request side
   always @(posedge clock) begin
      word_taken = req_tvalid && req_tready;
      if (word_taken) begin
         if (cur_word.mode == etm_pkg::MODE_WRITE)
            torque_map[cur_word.row*COLS + cur_word.col] = cur_word.torque;
         else if (cur_word.mode != etm_pkg::MODE_NONE)
            expected_answers.push_back(predict_answer(cur_word));
      end
   end

   always @(negedge clock) begin
      if (!reset && (word_taken || !req_tvalid)) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 2);
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            cur_word = pending_words.pop_front();
            req_tdata <= {6'd0, cur_word.torque, cur_word.col, cur_word.row,
                          cur_word.target, cur_word.pedal, cur_word.speed};
            req_tuser <= cur_word.mode;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
         word_taken = 1'b0;
      end
   end

   // result side
   always @(negedge clock) begin
      if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      map_rsp_type exp_word;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected word: kind %0d tdata %h", rsp_tuser, rsp_tdata);
            failed = 1'b1;
         end else begin
            exp_word = expected_answers.pop_front();
            if (rsp_tuser !== exp_word.kind) begin
               $error("result_kind: expected %0d, got %0d", exp_word.kind, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata[15:0] !== exp_word.torque) begin
               $error("torque_out: expected %0d, got %0d", exp_word.torque,
                      $signed(rsp_tdata[15:0]));
               failed = 1'b1;
            end
            if (rsp_tdata[31:16] !== exp_word.pedal) begin
               $error("pedal_out: expected %0d, got %0d", exp_word.pedal, rsp_tdata[31:16]);
               failed = 1'b1;
            end
            if (rsp_tdata[33:32] !== exp_word.status) begin
               $error("speed_status: expected %0d, got %0d", exp_word.status,
                      rsp_tdata[33:32]);
               failed = 1'b1;
            end
         end
      end
   end

endmodule

/* filelist.f */
hw/rtl/etm_pkg.sv
hw/rtl/etm_div.sv
hw/rtl/etm_table.sv
hw/rtl/engine_torque_map_lookup.sv
hw/rtl/etm_checker.sv
dv/engine_torque_map_lookup_tb.sv
